[rtl/trm_pkg.sv]
`default_nettype none

package trm_pkg;

  // Key geometry and value width are fixed by the word format.
  localparam int unsigned LEVEL_BITS = 9;
  localparam int unsigned KEY_BITS   = 3 * LEVEL_BITS;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned FANOUT     = 1 << LEVEL_BITS;

  typedef enum logic [1:0] {
    FUNC_PREPARE = 2'd0,
    FUNC_SET     = 2'd1,
    FUNC_GET     = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_UNPREPARED = 2'd1,
    STATUS_EXHAUSTED  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_TOP,
    S_WALK_MID,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic [1:0]            status;
  } out_t;

  // Allocation request from the walk and the pool's answer.
  typedef struct packed {
    logic commit;
    logic need_mid;
    logic need_leaf;
  } alloc_req_t;

  typedef struct packed {
    logic mid_ok;
    logic leaf_ok;
    logic exhausted;
  } alloc_rsp_t;

endpackage

`default_nettype wire

[rtl/trm_alloc.sv]
`default_nettype none

module trm_alloc #(
  parameter int unsigned MID_NODES  = 16,
  parameter int unsigned LEAF_NODES = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire trm_pkg::alloc_req_t                req_i,
  output trm_pkg::alloc_rsp_t                     rsp_o,
  output logic [$clog2(MID_NODES + 1)-1:0]        mid_node_o,
  output logic [$clog2(LEAF_NODES + 1)-1:0]       leaf_node_o
);

  localparam int unsigned MPW = $clog2(MID_NODES + 1);
  localparam int unsigned LPW = $clog2(LEAF_NODES + 1);

  logic [MPW-1:0] mid_used_q, mid_used_d;
  logic [LPW-1:0] leaf_used_q, leaf_used_d;
  logic           mid_avail, leaf_avail, mid_fail;

  always_comb begin
    mid_avail = (mid_used_q < MPW'(MID_NODES));
    leaf_avail = (leaf_used_q < LPW'(LEAF_NODES));
    mid_fail = req_i.need_mid & ~mid_avail;
    rsp_o.mid_ok = req_i.need_mid & mid_avail;
    // A leaf is only taken once the middle level is in place.
    rsp_o.leaf_ok = req_i.need_leaf & ~mid_fail & leaf_avail;
    rsp_o.exhausted = mid_fail | (req_i.need_leaf & ~mid_fail & ~leaf_avail);
    // Node numbers are stored plus one, so zero means empty.
    mid_node_o = MPW'(mid_used_q + 1'b1);
    leaf_node_o = LPW'(leaf_used_q + 1'b1);
  end

  always_comb begin
    mid_used_d = mid_used_q;
    leaf_used_d = leaf_used_q;
    if (req_i.commit && rsp_o.mid_ok) begin
      mid_used_d = mid_node_o;
    end
    if (req_i.commit && rsp_o.leaf_ok) begin
      leaf_used_d = leaf_node_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_used_q <= '0;
      leaf_used_q <= '0;
    end else begin
      mid_used_q <= mid_used_d;
      leaf_used_q <= leaf_used_d;
    end
  end

endmodule

`default_nettype wire

[rtl/three_level_radix_map.sv]
// Three-level radix map: a 27-bit key selects a value through a top table,
// a pool of middle nodes and a pool of leaf nodes, like a page table walk.
// Input channel (in_valid_i / in_stall_o / in_data_i): one word per item
// with func (prepare, set, get), key and value. Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result word per
// item with read_value and status, in order.
// Results are registered. The top table is read as the input word is
// taken, the middle pool in S_WALK_TOP and the leaf pool in S_WALK_MID:
// three dependent reads, one per level, of single-port synchronous
// memories (top, middle, leaf). The result is loaded into the output
// register from S_DONE. A new word is taken in the cycle the previous
// result is loaded, so a waiting result does not block the next input.
// Reset: the node counters clear at once, then a clearing pass writes
// zero to all three memories in parallel, each up to its depth;
// in_stall_o stays high.
// When the receiver stalls, the result holds in the output register; a
// following item walks up to its last step and waits there until the
// output register frees.

`default_nettype none

module three_level_radix_map #(
  parameter int unsigned MID_NODES  = 16,
  parameter int unsigned LEAF_NODES = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire trm_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output trm_pkg::out_t      out_data_o
);

  localparam int unsigned LB         = trm_pkg::LEVEL_BITS;
  localparam int unsigned VB         = trm_pkg::VALUE_BITS;
  localparam int unsigned TOP_DEPTH  = trm_pkg::FANOUT;
  localparam int unsigned MID_DEPTH  = MID_NODES * trm_pkg::FANOUT;
  localparam int unsigned LEAF_DEPTH = LEAF_NODES * trm_pkg::FANOUT;
  localparam int unsigned MAW        = $clog2(MID_DEPTH);
  localparam int unsigned LAW        = $clog2(LEAF_DEPTH);
  localparam int unsigned MPW        = $clog2(MID_NODES + 1);
  localparam int unsigned LPW        = $clog2(LEAF_NODES + 1);
  localparam int unsigned CLR_DEPTH  = (MID_DEPTH > LEAF_DEPTH) ? MID_DEPTH : LEAF_DEPTH;
  localparam int unsigned CW         = $clog2(CLR_DEPTH);

  // Storage: pointers are node number plus one, zero means not present.
  logic [MPW-1:0] top_mem  [TOP_DEPTH];
  logic [LPW-1:0] mid_mem  [MID_DEPTH];
  logic [VB-1:0]  leaf_mem [LEAF_DEPTH];

  trm_pkg::state_e state_q, state_d;
  trm_pkg::in_t    item_q;
  trm_pkg::out_t   out_data_q, out_data_d;
  logic            out_valid_q, out_valid_d;
  logic [CW-1:0]   clr_q, clr_d;
  logic            clr_done;

  logic [MPW-1:0]  top_rd_q;
  logic [LPW-1:0]  mid_rd_q;
  logic [VB-1:0]   leaf_rd_q;
  logic [1:0]      status_q, status_d;
  logic            hit_q, hit_d;

  logic            in_accept, out_free, result_load;
  logic [LB-1:0]   idx1, idx2, idx3, acc_idx1;
  logic [LPW-1:0]  leaf_ptr;
  logic [MPW-1:0]  mid_sel;

  logic                top_we;
  logic [LB-1:0]       top_wa;
  logic [MPW-1:0]      top_wd;
  logic                mid_we;
  logic [MAW-1:0]      mid_wa, mid_ra;
  logic [LPW-1:0]      mid_wd;
  logic                leaf_we;
  logic [LAW-1:0]      leaf_wa, leaf_ra;
  logic [VB-1:0]       leaf_wd;

  trm_pkg::alloc_req_t alloc_req;
  trm_pkg::alloc_rsp_t alloc_rsp;
  logic [MPW-1:0]      new_mid;
  logic [LPW-1:0]      new_leaf;

  trm_alloc #(
    .MID_NODES  (MID_NODES),
    .LEAF_NODES (LEAF_NODES)
  ) u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (alloc_req),
    .rsp_o       (alloc_rsp),
    .mid_node_o  (new_mid),
    .leaf_node_o (new_leaf)
  );

  // Split the key into level indices, high to low.
  assign idx1     = item_q.key[3*LB-1:2*LB];
  assign idx2     = item_q.key[2*LB-1:LB];
  assign idx3     = item_q.key[LB-1:0];
  assign acc_idx1 = in_data_i.key[3*LB-1:2*LB];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign clr_done  = (clr_q == CW'(CLR_DEPTH - 1));
  assign in_accept = in_valid_i && !in_stall_o;

  // Walk pointers: a leaf pointer only counts below a present middle node.
  assign leaf_ptr = (top_rd_q != '0) ? mid_rd_q : '0;
  assign mid_sel  = alloc_rsp.mid_ok ? new_mid : top_rd_q;
  assign mid_ra   = MAW'({MPW'(top_rd_q - 1'b1), idx2});
  assign leaf_ra  = LAW'({LPW'(leaf_ptr - 1'b1), idx3});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      trm_pkg::S_CLEAR: begin
        if (clr_done) state_d = trm_pkg::S_IDLE;
      end
      trm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = trm_pkg::S_WALK_TOP;
      end
      trm_pkg::S_WALK_TOP: state_d = trm_pkg::S_WALK_MID;
      trm_pkg::S_WALK_MID: state_d = trm_pkg::S_DONE;
      trm_pkg::S_DONE: begin
        if (out_free) begin
          state_d = in_valid_i ? trm_pkg::S_WALK_TOP : trm_pkg::S_IDLE;
        end
      end
      default: state_d = trm_pkg::S_CLEAR;
    endcase
  end

  // Control outputs: input handshake, allocation, memory writes, result.
  always_comb begin
    in_stall_o = 1'b1;
    result_load = 1'b0;
    alloc_req = '0;
    top_we = 1'b0;
    top_wa = clr_q[LB-1:0];
    top_wd = '0;
    mid_we = 1'b0;
    mid_wa = clr_q[MAW-1:0];
    mid_wd = '0;
    leaf_we = 1'b0;
    leaf_wa = clr_q[LAW-1:0];
    leaf_wd = '0;
    status_d = status_q;
    hit_d = hit_q;
    clr_d = clr_q;
    case (state_q)
      trm_pkg::S_CLEAR: begin
        // Sweep all three memories in parallel; each stops at its depth.
        top_we = ({1'b0, clr_q} < (CW + 1)'(TOP_DEPTH));
        mid_we = ({1'b0, clr_q} < (CW + 1)'(MID_DEPTH));
        leaf_we = ({1'b0, clr_q} < (CW + 1)'(LEAF_DEPTH));
        clr_d = CW'(clr_q + 1'b1);
      end
      trm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
      end
      trm_pkg::S_WALK_TOP: begin
        in_stall_o = 1'b1;
      end
      trm_pkg::S_WALK_MID: begin
        // Both pointers are known: allocate, write, or issue the leaf read.
        alloc_req.commit = (item_q.func == trm_pkg::FUNC_PREPARE);
        alloc_req.need_mid = (top_rd_q == '0);
        alloc_req.need_leaf = (leaf_ptr == '0);
        top_we = alloc_req.commit && alloc_rsp.mid_ok;
        top_wa = idx1;
        top_wd = new_mid;
        mid_we = alloc_req.commit && alloc_rsp.leaf_ok;
        mid_wa = MAW'({MPW'(mid_sel - 1'b1), idx2});
        mid_wd = new_leaf;
        leaf_we = (item_q.func == trm_pkg::FUNC_SET) && (leaf_ptr != '0);
        leaf_wa = leaf_ra;
        leaf_wd = item_q.value;
        hit_d = (item_q.func == trm_pkg::FUNC_GET) && (leaf_ptr != '0);
        if (alloc_req.commit && alloc_rsp.exhausted) begin
          status_d = trm_pkg::STATUS_EXHAUSTED;
        end else if ((item_q.func == trm_pkg::FUNC_SET) && (leaf_ptr == '0)) begin
          status_d = trm_pkg::STATUS_UNPREPARED;
        end else begin
          status_d = trm_pkg::STATUS_OK;
        end
      end
      trm_pkg::S_DONE: begin
        // Hand off the result and take the next word in the same cycle.
        result_load = out_free;
        in_stall_o = !out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (result_load) begin
      out_valid_d = 1'b1;
      out_data_d.read_value = hit_q ? leaf_rd_q : '0;
      out_data_d.status = status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trm_pkg::S_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the item, status and the result word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    status_q <= status_d;
    hit_q <= hit_d;
    out_data_q <= out_data_d;
  end

  // Top table: read on accept, written by allocation or the clearing pass.
  always_ff @(posedge clk_i) begin
    if (top_we) begin
      top_mem[top_wa] <= top_wd;
    end
    if (in_accept) begin
      top_rd_q <= top_mem[acc_idx1];
    end
  end

  // Middle node pool.
  always_ff @(posedge clk_i) begin
    if (mid_we) begin
      mid_mem[mid_wa] <= mid_wd;
    end
    if (state_q == trm_pkg::S_WALK_TOP) begin
      mid_rd_q <= mid_mem[mid_ra];
    end
  end

  // Leaf node pool.
  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    if (state_q == trm_pkg::S_WALK_MID) begin
      leaf_rd_q <= leaf_mem[leaf_ra];
    end
  end

endmodule

`default_nettype wire
